>>> rtl/tbs_pkg.sv
package tbs_pkg;

    localparam int unsigned STEP_FRAC_DEFAULT = 8;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_TILT_TOLERANCE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CREEP_SPEED    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_STEP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STEP       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TICKS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_TICKS  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITERATIONS = 3'd6;

    localparam logic [14:0] TILT_TOLERANCE_RST = 15'd1459;
    localparam logic [8:0]  CREEP_SPEED_RST    = 9'd67;
    localparam logic [23:0] START_STEP_RST     = 24'd1900;
    localparam logic [23:0] MIN_STEP_RST       = 24'd95;
    localparam logic [15:0] SETTLE_TICKS_RST   = 16'd50;
    localparam logic [15:0] CONFIRM_TICKS_RST  = 16'd150;
    localparam logic [9:0]  MAX_ITERATIONS_RST = 10'd500;

    localparam logic [8:0]  SPEED_LIMIT = 9'd400;
    localparam logic [23:0] TRAVEL_SAT  = 24'hFFFFFF;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SEARCHING = 3'd1;
    localparam logic [2:0] ST_CONFIRM   = 3'd2;
    localparam logic [2:0] ST_STABLE    = 3'd3;
    localparam logic [2:0] ST_MINSTEP   = 3'd4;
    localparam logic [2:0] ST_GAVEUP    = 3'd5;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_CREEP   = 7'b0000010,
        PH_SETTLE  = 7'b0000100,
        PH_CONFIRM = 7'b0001000,
        PH_STABLE  = 7'b0010000,
        PH_MINSTEP = 7'b0100000,
        PH_GAVEUP  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [14:0] tilt_tolerance;
        logic [8:0]  creep_speed;
        logic [23:0] start_step;
        logic [23:0] min_step;
        logic [15:0] settle_ticks;
        logic [15:0] confirm_ticks;
        logic [9:0]  max_iterations;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] pitch;
        logic signed [12:0] left_delta;
        logic signed [12:0] right_delta;
    } item_t;

    typedef struct packed {
        logic signed [9:0] motor_speed;
        logic [2:0]        status;
    } result_t;

endpackage

>>> rtl/tbs_if.sv
interface tbs_tick_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [15:0] pitch;
    logic signed [12:0] left_delta;
    logic signed [12:0] right_delta;

    modport source (output valid, mode, pitch, left_delta, right_delta, input ready);
    modport sink   (input valid, mode, pitch, left_delta, right_delta, output ready);
endinterface

interface tbs_result_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] motor_speed;
    logic [2:0]        status;

    modport source (output valid, motor_speed, status, input ready);
    modport sink   (input valid, motor_speed, status, output ready);
endinterface

interface tbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tbs_cfg_regs.sv
module tbs_cfg_regs (
    input  logic        clk,
    input  logic        rst_n,
    tbs_cfg_if.sink     cfg,
    output tbs_pkg::cfg_t regs
);
    import tbs_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TILT_TOLERANCE: regs_next.tilt_tolerance = cfg.data[14:0];
                CFG_CREEP_SPEED:    regs_next.creep_speed    = cfg.data[8:0];
                CFG_START_STEP:     regs_next.start_step     = cfg.data[23:0];
                CFG_MIN_STEP:       regs_next.min_step       = cfg.data[23:0];
                CFG_SETTLE_TICKS:   regs_next.settle_ticks   = cfg.data[15:0];
                CFG_CONFIRM_TICKS:  regs_next.confirm_ticks  = cfg.data[15:0];
                CFG_MAX_ITERATIONS: regs_next.max_iterations = cfg.data[9:0];
                default:            regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.tilt_tolerance <= TILT_TOLERANCE_RST;
            regs_reg.creep_speed    <= CREEP_SPEED_RST;
            regs_reg.start_step     <= START_STEP_RST;
            regs_reg.min_step       <= MIN_STEP_RST;
            regs_reg.settle_ticks   <= SETTLE_TICKS_RST;
            regs_reg.confirm_ticks  <= CONFIRM_TICKS_RST;
            regs_reg.max_iterations <= MAX_ITERATIONS_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

>>> rtl/tbs_core.sv
module tbs_core #(
    parameter int unsigned STEP_FRACTION_BITS = tbs_pkg::STEP_FRAC_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  tbs_pkg::item_t   item,
    input  tbs_pkg::cfg_t    regs,
    output tbs_pkg::result_t result
);
    import tbs_pkg::*;

    // wide enough for both travel << frac and step << 1
    localparam int unsigned CMP_W = 25 + STEP_FRACTION_BITS;

    phase_t      phase_reg, phase_next;
    logic [23:0] step_reg, step_next;
    logic        rev_reg, rev_next;
    logic        lsp_reg, lsp_next;
    logic [9:0]  iter_reg, iter_next;
    logic [15:0] tick_reg, tick_next;
    logic [23:0] travel_reg, travel_next;

    logic        pitch_pos;
    logic [15:0] pitch_abs;
    logic        in_band;
    logic signed [13:0] wheel_sum;
    logic [13:0] wheel_abs;
    logic [24:0] travel_sum;
    logic [23:0] travel_sat;
    logic        covered;
    logic        do_decide;
    logic        do_step;
    logic [8:0]  speed_mag;

    assign pitch_pos = !item.pitch[15];
    assign pitch_abs = item.pitch[15] ? 16'(-item.pitch) : item.pitch;
    assign in_band   = pitch_abs <= {1'b0, regs.tilt_tolerance};

    assign wheel_sum  = 14'(item.left_delta) + 14'(item.right_delta);
    assign wheel_abs  = wheel_sum[13] ? 14'(-wheel_sum) : wheel_sum;
    assign travel_sum = {1'b0, travel_reg} + 25'(wheel_abs);
    assign travel_sat = travel_sum[24] ? TRAVEL_SAT : travel_sum[23:0];
    assign covered    = (travel_sat == TRAVEL_SAT)
                     || ((CMP_W'(travel_sat) << STEP_FRACTION_BITS)
                         >= (CMP_W'(step_reg) << 1));

    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        rev_next    = rev_reg;
        lsp_next    = lsp_reg;
        iter_next   = iter_reg;
        tick_next   = tick_reg;
        travel_next = travel_reg;
        do_decide   = 1'b0;
        do_step     = 1'b0;

        if (item.mode)
        begin
            lsp_next  = pitch_pos;
            rev_next  = !pitch_pos;
            step_next = regs.start_step;
            iter_next = '0;
            do_decide = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_CONFIRM:
                begin
                    if (in_band)
                    begin
                        tick_next = tick_reg + 16'd1;
                        if (tick_next >= regs.confirm_ticks)
                        begin
                            phase_next = PH_STABLE;
                        end
                    end
                    else
                    begin
                        do_step = 1'b1;
                    end
                end
                PH_CREEP:
                begin
                    travel_next = travel_sat;
                    if (covered)
                    begin
                        tick_next  = '0;
                        phase_next = PH_SETTLE;
                    end
                end
                PH_SETTLE:
                begin
                    if (tick_reg < regs.settle_ticks)
                    begin
                        tick_next = tick_reg + 16'd1;
                    end
                    else
                    begin
                        // sign flip: overshot, halve and turn around
                        if (pitch_pos != lsp_reg)
                        begin
                            step_next = step_reg >> 1;
                            rev_next  = !rev_reg;
                        end
                        lsp_next  = pitch_pos;
                        iter_next = iter_reg + 10'd1;
                        do_decide = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (do_decide)
        begin
            if (iter_next >= regs.max_iterations)
            begin
                phase_next = PH_GAVEUP;
            end
            else if (in_band)
            begin
                tick_next  = '0;
                phase_next = (regs.confirm_ticks == '0) ? PH_STABLE : PH_CONFIRM;
            end
            else
            begin
                do_step = 1'b1;
            end
        end

        if (do_step)
        begin
            if (step_next < regs.min_step)
            begin
                phase_next = PH_MINSTEP;
            end
            else
            begin
                // fresh creep: zero travel is covered only by a zero step
                travel_next = '0;
                tick_next   = '0;
                phase_next  = (step_next == '0) ? PH_SETTLE : PH_CREEP;
            end
        end
    end

    assign speed_mag = (regs.creep_speed > SPEED_LIMIT) ? SPEED_LIMIT : regs.creep_speed;

    always_comb
    begin
        result.motor_speed = '0;
        if (phase_next == PH_CREEP)
        begin
            result.motor_speed = rev_next ? -$signed({1'b0, speed_mag})
                                          : $signed({1'b0, speed_mag});
        end
        unique case (phase_next)
            PH_IDLE:    result.status = ST_IDLE;
            PH_CREEP:   result.status = ST_SEARCHING;
            PH_SETTLE:  result.status = ST_SEARCHING;
            PH_CONFIRM: result.status = ST_CONFIRM;
            PH_STABLE:  result.status = ST_STABLE;
            PH_MINSTEP: result.status = ST_MINSTEP;
            PH_GAVEUP:  result.status = ST_GAVEUP;
            default:    result.status = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            step_reg   <= '0;
            rev_reg    <= 1'b0;
            lsp_reg    <= 1'b0;
            iter_reg   <= '0;
            tick_reg   <= '0;
            travel_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            rev_reg    <= rev_next;
            lsp_reg    <= lsp_next;
            iter_reg   <= iter_next;
            tick_reg   <= tick_next;
            travel_reg <= travel_next;
        end
    end

endmodule

>>> rtl/tilt_balance_step_halving_sweep.sv
// Channel  Dir  Payload                                   Beat
// -------  ---  ----------------------------------------  ---------------------------
// tick     in   mode, pitch, left_delta, right_delta      one tick or one start
// result   out  motor_speed, status                       one per tick beat
// cfg      in   index (3 b), data (24 b)                  one register write
//
// One beat per cycle sustained while result.ready stays high. A tick beat
// lands in the input register; when it advances, the decision logic updates
// the sweep state and the result lands in the output register.
// Reset (rst_n low, async) puts the sweep idle and loads register defaults.
// A stalled result holds its register; the input register still takes a
// beat behind it, then tick.ready drops until the result drains.
module tilt_balance_step_halving_sweep #(
    parameter int unsigned STEP_FRACTION_BITS = tbs_pkg::STEP_FRAC_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    tbs_tick_if.sink      tick,
    tbs_result_if.source  result,
    tbs_cfg_if.sink       cfg
);
    import tbs_pkg::*;

    cfg_t    regs;
    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg, res_valid_next;
    logic    advance;
    logic    accept;

    tbs_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tbs_core #(
        .STEP_FRACTION_BITS (STEP_FRACTION_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .regs    (regs),
        .result  (res_next)
    );

    // the held item moves on whenever the output slot is free or draining
    assign advance    = item_valid_reg && (!res_valid_reg || result.ready);
    assign tick.ready = !item_valid_reg || advance;
    assign accept     = tick.valid && tick.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.mode        <= tick.mode;
            item_reg.pitch       <= tick.pitch;
            item_reg.left_delta  <= tick.left_delta;
            item_reg.right_delta <= tick.right_delta;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.motor_speed = res_reg.motor_speed;
    assign result.status      = res_reg.status;

endmodule
